// ===== src/ps2_mouse_packet_decoder_unit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH

// Next-cycle implication, ignored while reset is high.
`define PMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmd check failed");

// Next-cycle implication that also holds across reset.
`define PMD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pmd check failed");

`endif

// ===== src/pmd_pkg.sv =====
`default_nettype none

package pmd_pkg;

   localparam int COORD_BITS      = 12;
   localparam int SUM_BITS        = COORD_BITS + 3;
   localparam int DELTA_BITS      = 11;
   localparam int TIMEOUT_BITS    = 16;
   localparam int ACCEL_BITS      = 8;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CMD_QUEUE_DEPTH = 4;

   // request kinds
   localparam logic REQ_DATA     = 1'b0;
   localparam logic REQ_RECENTER = 1'b1;

   // event kinds
   localparam logic [2:0] EV_MOVE         = 3'd0;
   localparam logic [2:0] EV_LBTN_PRESS   = 3'd1;
   localparam logic [2:0] EV_LBTN_RELEASE = 3'd2;
   localparam logic [2:0] EV_RBTN_PRESS   = 3'd3;
   localparam logic [2:0] EV_RBTN_RELEASE = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_X   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_Y   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEL   = 2'd3;

   localparam logic [COORD_BITS-1:0]   MAX_X_RESET   = COORD_BITS'(639);
   localparam logic [COORD_BITS-1:0]   MAX_Y_RESET   = COORD_BITS'(479);
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(50);
   localparam logic [ACCEL_BITS-1:0]   ACCEL_RESET   = ACCEL_BITS'(6);

   // header byte layout
   localparam logic [7:0] HDR_MASK   = 8'hC8;
   localparam logic [7:0] HDR_MATCH  = 8'h08;
   localparam int         HDR_X_SIGN = 4;
   localparam int         HDR_Y_SIGN = 5;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  data_byte;
      logic [31:0] time_ms;
   } req_word_type;

   typedef struct packed {
      logic [2:0]            event_kind;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic                  last_event;
   } rsp_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]   max_x;
      logic [COORD_BITS-1:0]   max_y;
      logic [TIMEOUT_BITS-1:0] resync_timeout_ms;
      logic [ACCEL_BITS-1:0]   accel_threshold;
   } cfg_type;

   // one assembled packet or a recenter request
   typedef struct packed {
      logic       recenter;
      logic [7:0] header;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } cmd_type;

endpackage

`default_nettype wire

// ===== src/pmd_cmd_fifo.sv =====
`default_nettype none

module pmd_cmd_fifo #(
   parameter int DEPTH = pmd_pkg::CMD_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pmd_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output pmd_pkg::cmd_type      head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   pmd_pkg::cmd_type    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full    = (count_ff == CNT_BITS'(DEPTH));
      empty   = (count_ff == '0);
      head    = slot_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== src/pmd_front.sv =====
`default_nettype none

module pmd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire pmd_pkg::req_word_type req_word,
   input  wire pmd_pkg::cfg_type      cfg,
   input  wire logic                  q_full,
   output logic                       q_push,
   output pmd_pkg::cmd_type           q_cmd
);

   localparam logic [1:0] CNT_NONE   = 2'd0;
   localparam logic [1:0] CNT_HEADER = 2'd1;
   localparam logic [1:0] CNT_X      = 2'd2;

   logic [1:0]  count_ff, count_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  x_byte_ff, x_byte_in;
   logic [31:0] start_ff, start_in;

   logic [31:0] elapsed;
   logic        timed_out;
   logic [1:0]  count_eff;
   logic        hdr_ok;
   logic        accept;

   always_comb begin
      accept    = push && !q_full;
      elapsed   = req_word.time_ms - start_ff;
      timed_out = (count_ff != CNT_NONE) && (elapsed > 32'(cfg.resync_timeout_ms));
      // a stale partial packet is dropped before the byte is looked at
      count_eff = timed_out ? CNT_NONE : count_ff;
      hdr_ok    = (req_word.data_byte & pmd_pkg::HDR_MASK) == pmd_pkg::HDR_MATCH;

      count_in  = count_ff;
      header_in = header_ff;
      x_byte_in = x_byte_ff;
      start_in  = start_ff;
      q_push    = 1'b0;
      q_cmd     = '{recenter: 1'b0, header: header_ff, x_byte: x_byte_ff,
                    y_byte: req_word.data_byte};

      if (accept) begin
         if (req_word.req_type == pmd_pkg::REQ_RECENTER) begin
            count_in       = CNT_NONE;
            q_push         = 1'b1;
            q_cmd.recenter = 1'b1;
         end else begin
            unique case (count_eff)
               CNT_NONE: begin
                  count_in = CNT_NONE;
                  if (hdr_ok) begin
                     header_in = req_word.data_byte;
                     start_in  = req_word.time_ms;
                     count_in  = CNT_HEADER;
                  end
               end
               CNT_HEADER: begin
                  x_byte_in = req_word.data_byte;
                  count_in  = CNT_X;
               end
               CNT_X: begin
                  count_in = CNT_NONE;
                  q_push   = 1'b1;
               end
               default: begin
                  count_in = CNT_NONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CNT_NONE;
         header_ff <= '0;
         x_byte_ff <= '0;
         start_ff  <= '0;
      end else begin
         count_ff  <= count_in;
         header_ff <= header_in;
         x_byte_ff <= x_byte_in;
         start_ff  <= start_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pmd_back.sv =====
`default_nettype none

module pmd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pmd_pkg::cfg_type cfg,
   input  wire logic             q_empty,
   input  wire pmd_pkg::cmd_type q_head,
   output logic                  q_pop,
   output logic                  empty,
   input  wire logic             pop,
   output pmd_pkg::rsp_word_type rsp_word
);

   localparam int CW = pmd_pkg::COORD_BITS;
   localparam int SB = pmd_pkg::SUM_BITS;
   localparam int DB = pmd_pkg::DELTA_BITS;

   localparam int PEND_MOVE  = 0;
   localparam int PEND_LEFT  = 1;
   localparam int PEND_RIGHT = 2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DELTA = 4'b0010,
      ST_MOVE  = 4'b0100,
      ST_EMIT  = 4'b1000
   } back_state_type;

   function automatic logic signed [DB-1:0] accel(input logic signed [DB-1:0] d,
                                                  input logic [pmd_pkg::ACCEL_BITS-1:0] thr);
      logic signed [DB-1:0] t;
      t = $signed(DB'(thr));
      if (d > t || d < -t) begin
         accel = d <<< 1;
      end else begin
         accel = d;
      end
   endfunction

   function automatic logic [CW-1:0] clamp(input logic signed [SB-1:0] p,
                                           input logic [CW-1:0] lim);
      if (p < 0) begin
         clamp = '0;
      end else if (p > $signed(SB'(lim))) begin
         clamp = lim;
      end else begin
         clamp = p[CW-1:0];
      end
   endfunction

   back_state_type        state_ff, state_in;
   pmd_pkg::cmd_type      cmd_ff, cmd_in;
   logic signed [DB-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [CW-1:0]         cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic [1:0]            prev_btn_ff, prev_btn_in;
   logic [2:0]            pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pmd_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic signed [8:0]     raw_x, raw_y;
   logic signed [SB-1:0]  sum_x, sum_y;
   logic [CW:0]           center_x, center_y;
   logic [1:0]            btn;
   logic [2:0]            rest;
   logic [2:0]            kind;
   logic                  rsp_take;
   logic                  load;

   always_comb begin
      raw_x    = $signed({cmd_ff.header[pmd_pkg::HDR_X_SIGN], cmd_ff.x_byte});
      raw_y    = $signed({cmd_ff.header[pmd_pkg::HDR_Y_SIGN], cmd_ff.y_byte});
      sum_x    = SB'($signed({1'b0, cursor_x_ff})) + SB'(dx_ff);
      sum_y    = SB'($signed({1'b0, cursor_y_ff})) + SB'(dy_ff);
      center_x = {1'b0, cfg.max_x} + (CW + 1)'(1);
      center_y = {1'b0, cfg.max_y} + (CW + 1)'(1);
      btn      = cmd_ff.header[1:0];
      rsp_take = pop && rsp_valid_ff;
      load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_take);

      // pending events go out in a fixed order: move, then left, then right
      rest = pend_ff;
      kind = pmd_pkg::EV_MOVE;
      priority if (pend_ff[PEND_MOVE]) begin
         kind            = pmd_pkg::EV_MOVE;
         rest[PEND_MOVE] = 1'b0;
      end else if (pend_ff[PEND_LEFT]) begin
         kind            = prev_btn_ff[0] ? pmd_pkg::EV_LBTN_PRESS : pmd_pkg::EV_LBTN_RELEASE;
         rest[PEND_LEFT] = 1'b0;
      end else begin
         kind             = prev_btn_ff[1] ? pmd_pkg::EV_RBTN_PRESS : pmd_pkg::EV_RBTN_RELEASE;
         rest[PEND_RIGHT] = 1'b0;
      end

      state_in    = state_ff;
      cmd_in      = cmd_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      prev_btn_in = prev_btn_ff;
      pend_in     = pend_ff;
      q_pop       = 1'b0;
      rsp_word_in = '{event_kind: kind, pos_x: cursor_x_ff, pos_y: cursor_y_ff,
                      last_event: (rest == '0)};

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            if (cmd_ff.recenter) begin
               cursor_x_in = center_x[CW:1];
               cursor_y_in = center_y[CW:1];
               state_in    = ST_IDLE;
            end else begin
               // dy is negated so that rows grow downward
               dx_in    = accel(DB'(raw_x), cfg.accel_threshold);
               dy_in    = accel(-DB'(raw_y), cfg.accel_threshold);
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            cursor_x_in          = clamp(sum_x, cfg.max_x);
            cursor_y_in          = clamp(sum_y, cfg.max_y);
            pend_in[PEND_MOVE]   = (dx_ff != '0) || (dy_ff != '0);
            pend_in[PEND_LEFT]   = btn[0] ^ prev_btn_ff[0];
            pend_in[PEND_RIGHT]  = btn[1] ^ prev_btn_ff[1];
            prev_btn_in          = btn;
            state_in             = (pend_in != '0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (load) begin
               pend_in = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);
      empty        = !rsp_valid_ff;
      rsp_word     = rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         prev_btn_ff  <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         prev_btn_ff  <= prev_btn_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      if (load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ps2_mouse_packet_decoder_unit.sv =====
// Channel   Direction  Handshake               Word
// request   in         push / full             req_word (req_type, data_byte, time_ms)
// response  out        empty / pop             rsp_word (event_kind, pos_x, pos_y, last_event)
// csr       in         csr_we, csr_index       csr_wdata
//
// A request word is taken every cycle while full is low; it goes through the
// front end into a QUEUE_DEPTH-entry command queue. The back-end sequencer
// pops a command in IDLE, reckons the deltas in DELTA (a recenter sets the
// cursor there), updates the cursor in MOVE and loads one event per EMIT step,
// while the front end keeps taking bytes. Reset is synchronous; there is no clearing pass.
// A held response stalls only the back end; full rises once the queue fills.
`default_nettype none

module ps2_mouse_packet_decoder_unit #(
   parameter int QUEUE_DEPTH = pmd_pkg::CMD_QUEUE_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire pmd_pkg::req_word_type                 req_word,
   output logic                                       empty,
   input  wire logic                                  pop,
   output pmd_pkg::rsp_word_type                      rsp_word,
   input  wire logic                                  csr_we,
   input  wire logic [pmd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [pmd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   pmd_pkg::cfg_type cfg_ff, cfg_in;
   pmd_pkg::cmd_type push_cmd, head_cmd;
   logic             q_push, q_pop, q_full, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pmd_pkg::CSR_MAX_X:   cfg_in.max_x = csr_wdata[pmd_pkg::COORD_BITS-1:0];
            pmd_pkg::CSR_MAX_Y:   cfg_in.max_y = csr_wdata[pmd_pkg::COORD_BITS-1:0];
            pmd_pkg::CSR_TIMEOUT: begin
               cfg_in.resync_timeout_ms = csr_wdata[pmd_pkg::TIMEOUT_BITS-1:0];
            end
            pmd_pkg::CSR_ACCEL: begin
               cfg_in.accel_threshold = csr_wdata[pmd_pkg::ACCEL_BITS-1:0];
            end
         endcase
      end
      full = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{max_x: pmd_pkg::MAX_X_RESET, max_y: pmd_pkg::MAX_Y_RESET,
                     resync_timeout_ms: pmd_pkg::TIMEOUT_RESET,
                     accel_threshold: pmd_pkg::ACCEL_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pmd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_word (req_word),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   pmd_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head_cmd)
   );

   pmd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_head   (head_cmd),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

// ===== src/pmd_checker.sv =====
`default_nettype none
`include "ps2_mouse_packet_decoder_unit_defines.svh"

module pmd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  full,
   input wire logic                  empty,
   input wire logic                  pop,
   input wire pmd_pkg::rsp_word_type rsp_word
);

   // reset leaves nothing queued on either side
   `PMD_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, empty && !full)

   // a waiting word holds until taken
   `PMD_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_word))

   // events of one packet leave back to back
   `PMD_ASSERT_NEXT(a_burst_follows, clock, reset, !empty && pop && !rsp_word.last_event, !empty)

   // events of one packet report the same position
   `PMD_ASSERT_NEXT(a_burst_pos, clock, reset, !empty && pop && !rsp_word.last_event, rsp_word.pos_x == $past(rsp_word.pos_x) && rsp_word.pos_y == $past(rsp_word.pos_y))

endmodule

bind ps2_mouse_packet_decoder_unit pmd_checker u_pmd_checker (.*);

`default_nettype wire

// ===== bench/pmd_event_checker.sv =====
module pmd_event_checker
   import pmd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic                      full,
   input  wire req_word_type              req_word,
   input  wire logic                      empty,
   input  wire logic                      pop,
   input  wire rsp_word_type              rsp_word,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned                    error_count,
   output int unsigned                    events_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type               cfg;
   logic [1:0]            byte_cnt;
   logic [7:0]            hdr_byte;
   logic [7:0]            dx_byte;
   logic [31:0]           start_ms;
   logic [COORD_BITS-1:0] cur_x;
   logic [COORD_BITS-1:0] cur_y;
   logic [1:0]            btn_prev;
   rsp_word_type          pending_events[$];

   function automatic int boost(input int d);
      int lim;
      lim = int'(cfg.accel_threshold);
      if (d > lim || d < -lim) begin
         return 2 * d;
      end
      return d;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_move(input logic [COORD_BITS-1:0] pos,
                                                        input int d,
                                                        input logic [COORD_BITS-1:0] lim);
      int p;
      p = int'(pos) + d;
      if (p < 0) begin
         p = 0;
      end
      if (p > int'(lim)) begin
         p = int'(lim);
      end
      return COORD_BITS'(p);
   endfunction

   // Updates the pointer state for one accepted word and queues its events.
   task automatic track_pointer(input req_word_type w);
      int           dx;
      int           dy;
      logic [1:0]   btn;
      logic [31:0]  gap;
      logic [2:0]   kinds[3];
      int           n;
      rsp_word_type ev;
      n = 0;
      if (w.req_type == REQ_RECENTER) begin
         byte_cnt = 2'd0;
         cur_x = COORD_BITS'((int'(cfg.max_x) + 1) / 2);
         cur_y = COORD_BITS'((int'(cfg.max_y) + 1) / 2);
      end else begin
         gap = w.time_ms - start_ms;
         if (byte_cnt != 2'd0 && gap > 32'(cfg.resync_timeout_ms)) begin
            byte_cnt = 2'd0;
         end
         case (byte_cnt)
            2'd0: begin
               if ((w.data_byte & HDR_MASK) == HDR_MATCH) begin
                  hdr_byte = w.data_byte;
                  start_ms = w.time_ms;
                  byte_cnt = 2'd1;
               end
            end
            2'd1: begin
               dx_byte  = w.data_byte;
               byte_cnt = 2'd2;
            end
            default: begin
               byte_cnt = 2'd0;
               btn = hdr_byte[1:0];
               dx  = int'(dx_byte) - (hdr_byte[HDR_X_SIGN] ? 256 : 0);
               dy  = (hdr_byte[HDR_Y_SIGN] ? 256 : 0) - int'(w.data_byte);
               dx  = boost(dx);
               dy  = boost(dy);
               cur_x = clamp_move(cur_x, dx, cfg.max_x);
               cur_y = clamp_move(cur_y, dy, cfg.max_y);
               if (dx != 0 || dy != 0) begin
                  kinds[n] = EV_MOVE;
                  n++;
               end
               if (btn[0] != btn_prev[0]) begin
                  kinds[n] = btn[0] ? EV_LBTN_PRESS : EV_LBTN_RELEASE;
                  n++;
               end
               if (btn[1] != btn_prev[1]) begin
                  kinds[n] = btn[1] ? EV_RBTN_PRESS : EV_RBTN_RELEASE;
                  n++;
               end
               btn_prev = btn;
               for (int i = 0; i < n; i++) begin
                  ev.event_kind = kinds[i];
                  ev.pos_x      = cur_x;
                  ev.pos_y      = cur_y;
                  ev.last_event = (i == n - 1);
                  pending_events.push_back(ev);
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type due;
      if (reset) begin
         cfg.max_x             = MAX_X_RESET;
         cfg.max_y             = MAX_Y_RESET;
         cfg.resync_timeout_ms = TIMEOUT_RESET;
         cfg.accel_threshold   = ACCEL_RESET;
         byte_cnt = 2'd0;
         hdr_byte = 8'd0;
         dx_byte  = 8'd0;
         start_ms = 32'd0;
         cur_x    = '0;
         cur_y    = '0;
         btn_prev = 2'd0;
         pending_events.delete();
         error_count <= 0;
         events_owed <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_X:   cfg.max_x             = csr_wdata[COORD_BITS-1:0];
               CSR_MAX_Y:   cfg.max_y             = csr_wdata[COORD_BITS-1:0];
               CSR_TIMEOUT: cfg.resync_timeout_ms = csr_wdata[TIMEOUT_BITS-1:0];
               CSR_ACCEL:   cfg.accel_threshold   = csr_wdata[ACCEL_BITS-1:0];
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (pending_events.size() == 0) begin
               $display("%0t: unexpected word kind=%0d x=%0d y=%0d last=%0b", $time,
                        rsp_word.event_kind, rsp_word.pos_x, rsp_word.pos_y,
                        rsp_word.last_event);
               error_count <= error_count + 1;
            end else begin
               due = pending_events.pop_front();
               if (rsp_word !== due) begin
                  $display({"%0t: mismatch expected kind=%0d x=%0d y=%0d last=%0b,",
                            " got kind=%0d x=%0d y=%0d last=%0b"},
                           $time, due.event_kind, due.pos_x, due.pos_y, due.last_event,
                           rsp_word.event_kind, rsp_word.pos_x, rsp_word.pos_y,
                           rsp_word.last_event);
                  error_count <= error_count + 1;
               end
            end
         end
         if (push && !full) begin
            track_pointer(req_word);
         end
         events_owed <= pending_events.size();
      end
   end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pmd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE      = 64;   // queue of quiet packets still draining
   localparam int unsigned HOLD_CYCLES = 400;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      push      = 1'b0;
   logic                      full;
   req_word_type              req_word  = '0;
   logic                      empty;
   logic                      pop       = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int unsigned               error_count;
   int unsigned               events_owed;

   int unsigned               send_idle_pct = 0;
   int unsigned               rsp_stall_pct = 0;
   logic                      hold_rsp      = 1'b0;
   int unsigned               items_sent    = 0;
   logic [31:0]               now_ms;
   logic [TIMEOUT_BITS-1:0]   timeout_ms;

   ps2_mouse_packet_decoder_unit i_dut (.*);

   pmd_event_checker i_checker (.*);

   always #5 clock = ~clock;

   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
         @(posedge clock);
      end
      $display("ps2_mouse_packet_decoder_unit test failed");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_word(input logic kind, input logic [7:0] data, input logic [31:0] stamp);
      req_word <= {kind, data, stamp};
      push     <= 1'b1;
      do @(posedge clock); while (full);
      items_sent++;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input int unsigned step);
      now_ms = now_ms + step;
      send_word(REQ_DATA, data, now_ms);
   endtask

   // the caller drops csr_we after the last write of a burst
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_TIMEOUT) begin
         timeout_ms = val;
      end
   endtask

   // wait until every event has come out and the command queue is quiet
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (events_owed != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_limits(input logic [15:0] mx, input logic [15:0] my,
                             input logic [15:0] tmo, input logic [15:0] acc);
      write_reg(CSR_MAX_X, mx);
      write_reg(CSR_MAX_Y, my);
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_ACCEL, acc);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] rand_header();
      return {2'b00, 2'($urandom), 1'b1, 3'($urandom)};
   endfunction

   // sign in bit 8, low byte in bits 7:0
   function automatic logic [8:0] small_delta();
      int d;
      d = int'($urandom_range(0, 40)) - 20;
      return 9'(d);
   endfunction

   task automatic random_packet();
      logic [7:0] hdr;
      logic [7:0] xb;
      logic [7:0] yb;
      logic [8:0] d;
      hdr = rand_header();
      if ($urandom_range(1) == 1) begin
         xb = 8'($urandom);
         yb = 8'($urandom);
      end else begin
         d = small_delta();
         hdr[HDR_X_SIGN] = d[8];
         xb = d[7:0];
         d = small_delta();
         hdr[HDR_Y_SIGN] = d[8];
         yb = d[7:0];
      end
      send_byte(hdr, $urandom_range(0, 100));
      send_byte(xb, $urandom_range(0, timeout_ms / 2));
      send_byte(yb, $urandom_range(0, timeout_ms / 2));
   endtask

   task automatic random_traffic(input int unsigned goal);
      int unsigned pick;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            random_packet();
         end else if (pick < 80) begin
            // packet cut short by a pause
            send_byte(rand_header(), $urandom_range(0, 100));
            if ($urandom_range(1) == 1) begin
               send_byte(8'($urandom), 0);
            end
            now_ms = now_ms + timeout_ms + 1 + $urandom_range(0, 50);
         end else if (pick < 88) begin
            send_byte(8'($urandom), $urandom_range(0, 3));
         end else if (pick < 95) begin
            send_word(REQ_RECENTER, 8'($urandom), now_ms);
         end else begin
            now_ms = $urandom;
            send_byte(8'($urandom), 0);
         end
      end
   endtask

   initial begin
      now_ms     = 32'hFFFF_FFE0;   // crosses the wrap early on
      timeout_ms = TIMEOUT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // quiet packet, then headers that must be dropped
      send_byte(8'h08, 1);
      send_byte(8'h00, 1);
      send_byte(8'h00, 1);
      send_byte(8'hC8, 1);
      send_byte(8'h48, 1);
      send_byte(8'h00, 1);
      // left down, largest positive dx, large upward dy
      send_byte(8'h09, 1);
      send_byte(8'hFF, 1);
      send_byte(8'h7F, 1);
      // both deltas at -256, left up, right down: three events
      send_byte(8'h3A, 1);
      send_byte(8'h00, 1);
      send_byte(8'h00, 1);
      // middle button down, right still held, no motion
      send_byte(8'h0E, 1);
      send_byte(8'h00, 1);
      send_byte(8'h00, 1);
      // dx equal to threshold, dy just above it, x byte exactly at the timeout
      send_byte(8'h28, 5);
      send_byte(8'h06, 50);
      send_byte(8'hF9, 0);
      // timed out, and the next byte is no header
      send_byte(8'h08, 1);
      send_byte(8'h05, 51);
      // timed out, and the next byte starts a new packet
      send_byte(8'h09, 1);
      send_byte(8'h08, 60);
      send_byte(8'h03, 1);
      send_byte(8'h00, 1);
      send_word(REQ_RECENTER, 8'hFF, now_ms);
      drain();

      random_traffic(items_sent + 35);
      send_word(REQ_RECENTER, 8'h00, now_ms);
      drain();

      // smallest limits; cursor sits above them
      set_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_idle_pct = 51;
      random_traffic(items_sent + 30);
      drain();

      set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_idle_pct = 0;
      rsp_stall_pct = 51;
      send_word(REQ_RECENTER, 8'h55, now_ms);
      random_traffic(items_sent + 35);
      drain();

      set_limits(16'd100, 16'd3000, 16'd20, 16'd3);
      send_idle_pct = 16;
      rsp_stall_pct = 16;
      random_traffic(items_sent + 15);
      // long hold-off on the result side while words keep coming
      send_idle_pct = 0;
      hold_rsp <= 1'b1;
      random_traffic(items_sent + 25);
      drain();

      if (error_count == 0) begin
         $display("ps2_mouse_packet_decoder_unit test passed");
      end else begin
         $display("ps2_mouse_packet_decoder_unit test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/pmd_pkg.sv
src/pmd_cmd_fifo.sv
src/pmd_front.sv
src/pmd_back.sv
src/ps2_mouse_packet_decoder_unit.sv
src/pmd_checker.sv
bench/pmd_event_checker.sv
bench/tb_top.sv
